>>> hw/rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, code unit constants and state codes for the JSON string
// unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

	localparam int unsigned UNIT_W   = 16;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned MODE_W   = 2;
	localparam int unsigned HCNT_W   = 2;
	localparam int unsigned HACC_W   = 12;

	// code units
	localparam logic [UNIT_W-1:0] CU_QUOTE  = 16'h0022;
	localparam logic [UNIT_W-1:0] CU_BSLASH = 16'h005C;
	localparam logic [UNIT_W-1:0] CU_SLASH  = 16'h002F;
	localparam logic [UNIT_W-1:0] CU_LC_B   = 16'h0062;
	localparam logic [UNIT_W-1:0] CU_LC_F   = 16'h0066;
	localparam logic [UNIT_W-1:0] CU_LC_N   = 16'h006E;
	localparam logic [UNIT_W-1:0] CU_LC_R   = 16'h0072;
	localparam logic [UNIT_W-1:0] CU_LC_T   = 16'h0074;
	localparam logic [UNIT_W-1:0] CU_LC_U   = 16'h0075;
	localparam logic [UNIT_W-1:0] CU_BS     = 16'h0008;
	localparam logic [UNIT_W-1:0] CU_FF     = 16'h000C;
	localparam logic [UNIT_W-1:0] CU_LF     = 16'h000A;
	localparam logic [UNIT_W-1:0] CU_CR     = 16'h000D;
	localparam logic [UNIT_W-1:0] CU_TAB    = 16'h0009;

	// result status
	localparam logic [STATUS_W-1:0] ST_CHAR = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DONE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ERR  = 2'd2;

	// parser modes
	localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_STR  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ESC  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_HEX  = 2'd3;

	localparam logic [HCNT_W-1:0] HCNT_LAST = 2'd3;

	typedef struct packed {
		logic [UNIT_W-1:0] code_unit;
		logic              starts_string;
		logic              final_unit;
	} item_t;

	typedef struct packed {
		logic [UNIT_W-1:0]   decoded_unit;
		logic [STATUS_W-1:0] status;
	} result_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [HCNT_W-1:0] hex_count;
		logic [HACC_W-1:0] hex_accum;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		mode:      MODE_IDLE,
		hex_count: '0,
		hex_accum: '0
	};

	// {is_hex, nibble}
	function automatic logic [4:0] hex_digit(input logic [UNIT_W-1:0] u);
		logic [4:0] r;
		r = '0;
		if (u >= 16'h0030 && u <= 16'h0039) begin
			r = {1'b1, u[3:0]};
		end else if ((u >= 16'h0061 && u <= 16'h0066) ||
		             (u >= 16'h0041 && u <= 16'h0046)) begin
			r = {1'b1, u[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/jsu_in_if.sv
// ----------------------------------------------------------------------------
// jsu_in_if
// Valid/ready channel carrying one code unit request with its markers.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsu_in_if;
	logic                      valid;
	logic                      ready;
	logic [jsu_pkg::UNIT_W-1:0] code_unit;
	logic                      starts_string;
	logic                      final_unit;

	modport source (output valid, output code_unit, output starts_string,
		output final_unit, input ready);
	modport sink (input valid, input code_unit, input starts_string,
		input final_unit, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/jsu_out_if.sv
// ----------------------------------------------------------------------------
// jsu_out_if
// Valid/ready channel carrying one decoded unit or string status request.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsu_out_if;
	logic                        valid;
	logic                        ready;
	logic [jsu_pkg::UNIT_W-1:0]   decoded_unit;
	logic [jsu_pkg::STATUS_W-1:0] status;

	modport source (output valid, output decoded_unit, output status, input ready);
	modport sink (input valid, input decoded_unit, input status, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/json_string_unescaper_unit.sv
// ----------------------------------------------------------------------------
// json_string_unescaper_unit
// Decodes quoted JSON strings one 16-bit code unit per request.
//
// Channels: text (sink) takes code_unit with starts_string and final_unit;
// result (source) gives decoded_unit with status (0 unit, 1 string closed,
// 2 malformed or truncated). A unit that produces nothing (opening quote,
// backslash, u, leading hex digits, units outside a string) gives no result.
// A unit taken into the input register is decoded from there, and its
// result is held in the result register, which drives result.
// Throughput: one unit per cycle while result does not stall, set by the
// parser state update between the input register and the result register.
// When result stalls, one unit waits in the input register while the held
// result is pending; text.ready drops only when both are full.
// Reset clears both registers and returns the parser to idle, waiting for
// a unit marked starts_string.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescaper_unit (
	input  wire        clk,
	input  wire        arst_n,
	jsu_in_if.sink     text,
	jsu_out_if.source  result
);

	logic                  valid_s1;
	jsu_pkg::item_t        item_s1;
	jsu_pkg::parse_state_t state_q;
	jsu_pkg::parse_state_t state_d;
	logic                  step_valid;
	jsu_pkg::result_t      step_res;
	logic                  res_valid_q;
	jsu_pkg::result_t      res_q;
	logic                  advance;

	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign text.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			item_s1 <= '{code_unit: text.code_unit, starts_string: text.starts_string,
				final_unit: text.final_unit};
		end
	end

	jsu_step u_step (
		.state      (state_q),
		.item       (item_s1),
		.state_next (state_d),
		.res_valid  (step_valid),
		.res        (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= jsu_pkg::STATE_RESET;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			state_q     <= state_d;
			res_valid_q <= step_valid;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_valid) begin
			res_q <= step_res;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.decoded_unit = res_q.decoded_unit;
	assign result.status       = res_q.status;

endmodule

`default_nettype wire

>>> hw/rtl/jsu_step.sv
// ----------------------------------------------------------------------------
// jsu_step
// Next-state and result logic for one code unit of the unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_step (
	input  jsu_pkg::parse_state_t state,
	input  jsu_pkg::item_t        item,
	output jsu_pkg::parse_state_t state_next,
	output logic                  res_valid,
	output jsu_pkg::result_t      res
);

	logic [jsu_pkg::UNIT_W-1:0] u;
	logic                       last;
	logic [4:0]                 hd;
	logic                       emit;
	logic [jsu_pkg::UNIT_W-1:0] emit_val;

	assign u    = item.code_unit;
	assign last = item.final_unit;
	assign hd   = jsu_pkg::hex_digit(u);

	always_comb begin
		state_next = state;
		res_valid  = 1'b0;
		res        = '{decoded_unit: '0, status: jsu_pkg::ST_ERR};
		emit       = 1'b0;
		emit_val   = u;

		if (item.starts_string) begin
			state_next = jsu_pkg::STATE_RESET;
			if (u != jsu_pkg::CU_QUOTE || last) begin
				res_valid = 1'b1;
			end else begin
				state_next.mode = jsu_pkg::MODE_STR;
			end
		end else begin
			unique case (state.mode)
				jsu_pkg::MODE_IDLE: begin
				end
				jsu_pkg::MODE_STR: begin
					if (u == jsu_pkg::CU_QUOTE) begin
						state_next.mode = jsu_pkg::MODE_IDLE;
						res_valid       = 1'b1;
						res.status      = jsu_pkg::ST_DONE;
					end else if (u == jsu_pkg::CU_BSLASH) begin
						if (last) begin
							state_next = jsu_pkg::STATE_RESET;
							res_valid  = 1'b1;
						end else begin
							state_next.mode = jsu_pkg::MODE_ESC;
						end
					end else begin
						emit = 1'b1;
					end
				end
				jsu_pkg::MODE_ESC: begin
					if (u == jsu_pkg::CU_LC_U) begin
						state_next = jsu_pkg::STATE_RESET;
						if (last) begin
							res_valid = 1'b1;
						end else begin
							state_next.mode = jsu_pkg::MODE_HEX;
						end
					end else begin
						emit = 1'b1;
						unique case (u)
							jsu_pkg::CU_LC_B: emit_val = jsu_pkg::CU_BS;
							jsu_pkg::CU_LC_F: emit_val = jsu_pkg::CU_FF;
							jsu_pkg::CU_LC_N: emit_val = jsu_pkg::CU_LF;
							jsu_pkg::CU_LC_R: emit_val = jsu_pkg::CU_CR;
							jsu_pkg::CU_LC_T: emit_val = jsu_pkg::CU_TAB;
							jsu_pkg::CU_SLASH: emit_val = jsu_pkg::CU_SLASH;
							default: emit_val = u;
						endcase
					end
				end
				jsu_pkg::MODE_HEX: begin
					if (!hd[4]) begin
						state_next = jsu_pkg::STATE_RESET;
						res_valid  = 1'b1;
					end else if (state.hex_count == jsu_pkg::HCNT_LAST) begin
						state_next.hex_count = '0;
						state_next.hex_accum = '0;
						emit     = 1'b1;
						emit_val = {state.hex_accum, hd[3:0]};
					end else if (last) begin
						state_next = jsu_pkg::STATE_RESET;
						res_valid  = 1'b1;
					end else begin
						state_next.hex_accum = {state.hex_accum[jsu_pkg::HACC_W-5:0], hd[3:0]};
						state_next.hex_count = state.hex_count + 2'd1;
					end
				end
				default: begin
					state_next.mode = jsu_pkg::MODE_IDLE;
				end
			endcase
		end

		if (emit) begin
			res_valid = 1'b1;
			if (last) begin
				state_next = jsu_pkg::STATE_RESET;
			end else begin
				state_next.mode  = jsu_pkg::MODE_STR;
				res.decoded_unit = emit_val;
				res.status       = jsu_pkg::ST_CHAR;
			end
		end
	end

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for json_string_unescaper_unit. Code unit requests
// come from a queue and go out in random bursts. The receiver stalls on its
// own random pattern. A decoder model inside the bench predicts the decoded
// unit and status of every accepted unit, and each result is checked in
// order against it. A short directed part covers the escapes and the error
// cases. Most of the random part is well-formed strings, with some broken
// strings and noise mixed in.
// ----------------------------------------------------------------------------

module tb;

	typedef struct packed {
		logic           hold;
		jsu_pkg::item_t unit;
	} text_req_t;

	localparam logic [jsu_pkg::UNIT_W-1:0] SIMPLE_ESC [8] = '{jsu_pkg::CU_QUOTE,
		jsu_pkg::CU_BSLASH, jsu_pkg::CU_SLASH, jsu_pkg::CU_LC_B, jsu_pkg::CU_LC_F,
		jsu_pkg::CU_LC_N, jsu_pkg::CU_LC_R, jsu_pkg::CU_LC_T};
	localparam logic [jsu_pkg::UNIT_W-1:0] NEAR_HEX [8] = '{16'h002F, 16'h003A, 16'h0040,
		16'h0047, 16'h0060, 16'h0067, 16'h1030, 16'h0141};

	logic clk;
	logic arst_n;

	jsu_in_if  text_ch ();
	jsu_out_if result_ch ();

	json_string_unescaper_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.result (result_ch)
	);

	text_req_t          text_q [$];
	jsu_pkg::result_t   awaited_q [$];
	int unsigned        mismatches = 0;
	int unsigned        random_units;
	logic               drained;

	// decoder model state
	logic [jsu_pkg::MODE_W-1:0] str_mode;
	logic [1:0]                 hex_digits;
	logic [15:0]                hex_value;

	int gap_left;
	int burst_left;
	int stall_left;
	int calm_left;

	jsu_pkg::result_t want;
	jsu_pkg::item_t   taken;

	task automatic report_mismatch(input string msg);
		if (mismatches < 40) begin
			$display("%0t ERROR %s", $time, msg);
		end
		mismatches++;
	endtask

	function automatic int hex_nibble(input logic [jsu_pkg::UNIT_W-1:0] u);
		if (u >= 16'h0030 && u <= 16'h0039) return int'(u - 16'h0030);
		if (u >= 16'h0061 && u <= 16'h0066) return int'(u - 16'h0061) + 10;
		if (u >= 16'h0041 && u <= 16'h0046) return int'(u - 16'h0041) + 10;
		return -1;
	endfunction

	function automatic bit abort_string(output jsu_pkg::result_t res);
		str_mode   = jsu_pkg::MODE_IDLE;
		hex_digits = '0;
		hex_value  = '0;
		res = '{decoded_unit: '0, status: jsu_pkg::ST_ERR};
		return 1'b1;
	endfunction

	function automatic bit emit_char(input logic [jsu_pkg::UNIT_W-1:0] u, input logic last,
		output jsu_pkg::result_t res);
		str_mode = jsu_pkg::MODE_STR;
		if (last) return abort_string(res);
		res = '{decoded_unit: u, status: jsu_pkg::ST_CHAR};
		return 1'b1;
	endfunction

	// returns 1 when the unit produces a result
	function automatic bit unescape_step(input jsu_pkg::item_t it,
		output jsu_pkg::result_t res);
		int          nib;
		logic [15:0] decoded;
		res = '0;
		if (it.starts_string) begin
			hex_digits = '0;
			hex_value  = '0;
			if (it.code_unit != jsu_pkg::CU_QUOTE || it.final_unit) begin
				return abort_string(res);
			end
			str_mode = jsu_pkg::MODE_STR;
			return 1'b0;
		end
		case (str_mode)
			jsu_pkg::MODE_STR: begin
				if (it.code_unit == jsu_pkg::CU_QUOTE) begin
					str_mode = jsu_pkg::MODE_IDLE;
					res = '{decoded_unit: '0, status: jsu_pkg::ST_DONE};
					return 1'b1;
				end
				if (it.code_unit == jsu_pkg::CU_BSLASH) begin
					if (it.final_unit) return abort_string(res);
					str_mode = jsu_pkg::MODE_ESC;
					return 1'b0;
				end
				return emit_char(it.code_unit, it.final_unit, res);
			end
			jsu_pkg::MODE_ESC: begin
				case (it.code_unit)
					jsu_pkg::CU_LC_B: return emit_char(jsu_pkg::CU_BS, it.final_unit, res);
					jsu_pkg::CU_LC_F: return emit_char(jsu_pkg::CU_FF, it.final_unit, res);
					jsu_pkg::CU_LC_N: return emit_char(jsu_pkg::CU_LF, it.final_unit, res);
					jsu_pkg::CU_LC_R: return emit_char(jsu_pkg::CU_CR, it.final_unit, res);
					jsu_pkg::CU_LC_T: return emit_char(jsu_pkg::CU_TAB, it.final_unit, res);
					jsu_pkg::CU_LC_U: begin
						if (it.final_unit) return abort_string(res);
						str_mode   = jsu_pkg::MODE_HEX;
						hex_digits = '0;
						hex_value  = '0;
						return 1'b0;
					end
					default: return emit_char(it.code_unit, it.final_unit, res);
				endcase
			end
			jsu_pkg::MODE_HEX: begin
				nib = hex_nibble(it.code_unit);
				if (nib < 0) return abort_string(res);
				hex_value = {hex_value[11:0], nib[3:0]};
				if (hex_digits == 2'd3) begin
					decoded    = hex_value;
					hex_digits = '0;
					hex_value  = '0;
					return emit_char(decoded, it.final_unit, res);
				end
				if (it.final_unit) return abort_string(res);
				hex_digits = hex_digits + 2'd1;
				return 1'b0;
			end
			default: begin
				str_mode = jsu_pkg::MODE_IDLE;
				return 1'b0;
			end
		endcase
	endfunction

	function automatic jsu_pkg::item_t mk(input logic [jsu_pkg::UNIT_W-1:0] u,
		input bit st = 1'b0);
		return '{code_unit: u, starts_string: st, final_unit: 1'b0};
	endfunction

	function automatic logic [jsu_pkg::UNIT_W-1:0] plain_unit();
		logic [jsu_pkg::UNIT_W-1:0] u;
		do begin
			u = 16'($urandom_range(0, 65535));
		end while (u == jsu_pkg::CU_QUOTE || u == jsu_pkg::CU_BSLASH);
		return u;
	endfunction

	function automatic logic [jsu_pkg::UNIT_W-1:0] hex_char();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10) return 16'(16'h0030 + v);
		return 16'(($urandom_range(0, 1) ? 16'h0061 : 16'h0041) + v - 10);
	endfunction

	function automatic logic [jsu_pkg::UNIT_W-1:0] non_hex_char();
		logic [jsu_pkg::UNIT_W-1:0] u;
		do begin
			u = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535)) :
				NEAR_HEX[$urandom_range(0, 7)];
		end while (hex_nibble(u) >= 0);
		return u;
	endfunction

	task automatic put(input jsu_pkg::item_t it, input bit hold = 1'b0);
		text_req_t r;
		r = '{hold: hold, unit: it};
		text_q.insert(text_q.size(), r);
	endtask

	task automatic queue_random_string(input bit hold);
		jsu_pkg::item_t s [$];
		jsu_pkg::item_t x;
		int             k;
		int             cut;
		s.insert(s.size(), mk(jsu_pkg::CU_QUOTE, 1'b1));
		repeat ($urandom_range(0, 10)) begin
			case ($urandom_range(0, 12))
				0, 1, 2, 3: s.insert(s.size(), mk(plain_unit()));
				4: begin
					s.insert(s.size(), mk(jsu_pkg::CU_BSLASH));
					s.insert(s.size(), mk(SIMPLE_ESC[$urandom_range(0, 7)]));
				end
				5: begin
					s.insert(s.size(), mk(jsu_pkg::CU_BSLASH));
					s.insert(s.size(), mk(16'($urandom_range(0, 65535))));
				end
				6, 7, 8: begin
					s.insert(s.size(), mk(jsu_pkg::CU_BSLASH));
					s.insert(s.size(), mk(jsu_pkg::CU_LC_U));
					repeat (4) s.insert(s.size(), mk(hex_char()));
				end
				9: begin
					s.insert(s.size(), mk(jsu_pkg::CU_BSLASH));
					s.insert(s.size(), mk(jsu_pkg::CU_LC_U));
					repeat ($urandom_range(0, 3)) s.insert(s.size(), mk(hex_char()));
					s.insert(s.size(), mk(non_hex_char()));
				end
				10: s.insert(s.size(), mk($urandom_range(0, 1) ? 16'hFFFF : 16'h0000));
				default: begin
					do begin
						x = mk(16'($urandom_range(16'h0020, 16'h007E)));
					end while (x.code_unit == jsu_pkg::CU_QUOTE ||
						x.code_unit == jsu_pkg::CU_BSLASH);
					s.insert(s.size(), x);
				end
			endcase
		end
		s.insert(s.size(), mk(jsu_pkg::CU_QUOTE));
		case ($urandom_range(0, 19))
			0, 1, 2: begin
				cut = $urandom_range(0, s.size() - 1);
				s[cut].final_unit = 1'b1;
				while (s.size() > cut + 1) s.delete(s.size() - 1);
			end
			3: begin
				do begin
					s[0].code_unit = 16'($urandom_range(0, 65535));
				end while (s[0].code_unit == jsu_pkg::CU_QUOTE);
				s[0].final_unit = 1'($urandom_range(0, 1));
			end
			4: begin
				k = $urandom_range(1, s.size() - 1);
				s.insert(k, mk(jsu_pkg::CU_QUOTE, 1'b1));
			end
			5: s[s.size() - 1].final_unit = 1'b1;
			default: ;
		endcase
		foreach (s[i]) put(s[i], hold && i == 0);
		random_units += s.size();
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				x = mk(16'($urandom_range(0, 65535)));
				x.final_unit = 1'($urandom_range(0, 1));
				if ($urandom_range(0, 2) == 0) x.code_unit = jsu_pkg::CU_QUOTE;
				put(x);
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// sender: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_ch.valid         <= 1'b0;
			text_ch.code_unit     <= '0;
			text_ch.starts_string <= 1'b0;
			text_ch.final_unit    <= 1'b0;
			gap_left              <= 0;
			burst_left            <= 4;
		end else if (!text_ch.valid || text_ch.ready) begin
			if (gap_left != 0) begin
				text_ch.valid <= 1'b0;
				gap_left      <= gap_left - 1;
			end else if (text_q.size() != 0 &&
				(!text_q[0].hold || (!text_ch.valid && drained))) begin
				text_ch.valid         <= 1'b1;
				text_ch.code_unit     <= text_q[0].unit.code_unit;
				text_ch.starts_string <= text_q[0].unit.starts_string;
				text_ch.final_unit    <= text_q[0].unit.final_unit;
				void'(text_q.pop_front());
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 30);
					gap_left   <= ($urandom_range(0, 3) == 0) ? $urandom_range(4, 15) :
						$urandom_range(0, 3);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				text_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: calm stretches, stall runs and choppy ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_left      <= 0;
			calm_left       <= 0;
		end else if (stall_left != 0) begin
			result_ch.ready <= 1'b0;
			stall_left      <= stall_left - 1;
		end else if (calm_left != 0) begin
			result_ch.ready <= 1'b1;
			calm_left       <= calm_left - 1;
		end else begin
			case ($urandom_range(0, 9))
				0: begin
					result_ch.ready <= 1'b1;
					calm_left       <= $urandom_range(20, 80);
				end
				1, 2: begin
					result_ch.ready <= 1'b0;
					stall_left      <= $urandom_range(1, 10);
				end
				default: result_ch.ready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// monitor: check results, then predict from the accepted request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			str_mode   = jsu_pkg::MODE_IDLE;
			hex_digits = '0;
			hex_value  = '0;
			drained    <= 1'b1;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (awaited_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result unit %h status %0d",
						result_ch.decoded_unit, result_ch.status));
				end else begin
					want = awaited_q.pop_front();
					if (result_ch.decoded_unit !== want.decoded_unit) begin
						report_mismatch($sformatf("decoded_unit %h, want %h",
							result_ch.decoded_unit, want.decoded_unit));
					end
					if (result_ch.status !== want.status) begin
						report_mismatch($sformatf("status %0d, want %0d",
							result_ch.status, want.status));
					end
				end
			end
			if (text_ch.valid && text_ch.ready) begin
				taken = '{code_unit: text_ch.code_unit, starts_string: text_ch.starts_string,
					final_unit: text_ch.final_unit};
				if (unescape_step(taken, want)) awaited_q.insert(awaited_q.size(), want);
			end
			drained <= (awaited_q.size() == 0);
		end
	end

	initial begin
		#2ms;
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		random_units = 0;

		// directed: start without quote, idle unit, truncated opening quote
		put(mk(16'hFFFF, 1'b1));
		put(mk(16'h0000));
		put('{code_unit: jsu_pkg::CU_QUOTE, starts_string: 1'b1, final_unit: 1'b1});
		// every simple escape plus an unknown one, then close
		put(mk(jsu_pkg::CU_QUOTE, 1'b1));
		foreach (SIMPLE_ESC[i]) begin
			put(mk(jsu_pkg::CU_BSLASH));
			put(mk(SIMPLE_ESC[i]));
		end
		put(mk(jsu_pkg::CU_BSLASH));
		put(mk(16'hFFFF));
		put(mk(jsu_pkg::CU_QUOTE));
		// mixed-case hex escape, restart mid-escape, bad hex digit
		put(mk(jsu_pkg::CU_QUOTE, 1'b1));
		put(mk(jsu_pkg::CU_BSLASH));
		put(mk(jsu_pkg::CU_LC_U));
		put(mk(16'h0061));
		put(mk(16'h0046));
		put(mk(16'h0030));
		put(mk(16'h0039));
		put(mk(jsu_pkg::CU_BSLASH));
		put(mk(jsu_pkg::CU_QUOTE, 1'b1));
		put(mk(jsu_pkg::CU_BSLASH));
		put(mk(jsu_pkg::CU_LC_U));
		put(mk(16'h0067));

		// random strings; the first one waits for all results to drain
		queue_random_string(1'b1);
		while (random_units < 450) begin
			queue_random_string($urandom_range(0, 39) == 0);
		end

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		do begin
			@(negedge clk);
		end while (text_q.size() != 0 || text_ch.valid || awaited_q.size() != 0);
		repeat (20) @(negedge clk);

		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
